### design/nd_array_slice_chunk_generator_defines.svh
// Assertion macros used by ndslice_checker.
`ifndef ND_ARRAY_SLICE_CHUNK_GENERATOR_DEFINES_SVH
`define ND_ARRAY_SLICE_CHUNK_GENERATOR_DEFINES_SVH

// Same-cycle implication
`define NDS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nds check failed");

// Next-cycle implication
`define NDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nds check failed");

`endif

### design/ndslice_pkg.sv
// ----------------------------------------------------------------------------
// ndslice_pkg
// Shared codes and controller/datapath interface types for the slice generator.
// ----------------------------------------------------------------------------
package ndslice_pkg;

   localparam int NUM_SIZE_REGS = 4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   localparam logic [2:0] STAT_OK    = 3'd0;
   localparam logic [2:0] STAT_EMPTY = 3'd1;
   localparam logic [2:0] STAT_WHOLE = 3'd2;
   localparam logic [2:0] STAT_ZSTEP = 3'd3;
   localparam logic [2:0] STAT_OOB   = 3'd4;
   localparam logic [2:0] STAT_NONE  = 3'd5;

   localparam logic [2:0] CSR_DIM_COUNT = 3'd0;
   localparam logic [2:0] CSR_SIZE0     = 3'd1;
   localparam logic [2:0] CSR_SIZE1     = 3'd2;
   localparam logic [2:0] CSR_SIZE2     = 3'd3;
   localparam logic [2:0] CSR_SIZE3     = 3'd4;
   localparam logic [2:0] CSR_SLICE_DIM = 3'd5;

   typedef struct packed {
      logic take_start;
      logic take_next;
      logic div_step;
      logic check;
      logic prod_step;
      logic fin1;
      logic fin2;
      logic fin3;
      logic fin4;
   } cmd_type;

   typedef struct packed {
      logic pre_fail;
      logic div_last;
      logic oob;
      logic prod_last;
   } stat_type;

endpackage

### design/ndslice_if.sv
// ----------------------------------------------------------------------------
// ndslice channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface ndslice_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] range_start;
   logic [31:0] range_step;
   logic [31:0] range_end;
   modport source (output valid, operation, range_start, range_step, range_end,
                   input ready);
   modport sink   (input valid, operation, range_start, range_step, range_end,
                   output ready);
endinterface

interface ndslice_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] slice_width;
   logic [31:0] slice_count;
   logic [31:0] src_offset;
   logic [31:0] dst_offset;
   logic [31:0] chunk_len;
   logic        last_chunk;
   modport source (output valid, status, slice_width, slice_count, src_offset,
                   dst_offset, chunk_len, last_chunk, input ready);
   modport sink   (input valid, status, slice_width, slice_count, src_offset,
                   dst_offset, chunk_len, last_chunk, output ready);
endinterface

interface ndslice_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/nd_array_slice_chunk_generator.sv
// ----------------------------------------------------------------------------
// nd_array_slice_chunk_generator
// Plans copy chunks for slicing a row-major array of up to four dimensions.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A next-chunk request builds its chunk in
// the result register when it is accepted, and the chunk is then held in S_OUT
// until taken; the walker makes a single update per chunk. A start request
// that fails its early checks goes straight to S_OUT; one that fails the bounds
// check runs the divider and S_CHK first, and one that passes it goes on
// through the product loop over each dimension and S_FIN1 to S_FIN4. The
// 32-step restoring divider finds the slice width and the one shared
// 64x16 multiplier forms the dimension products. Register writes are
// taken every cycle and must only be made while the block is idle.
module nd_array_slice_chunk_generator #(
   parameter int MAX_DIMS      = 4,
   parameter int DIM_SIZE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   ndslice_req_if.sink        req_chan,
   ndslice_rsp_if.source      rsp_chan,
   ndslice_csr_if.sink        csr_chan
);

   ndslice_pkg::cmd_type  cmd;
   ndslice_pkg::stat_type stat;

   assign csr_chan.ready = 1'b1;

   ndslice_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ndslice_dp #(
      .MAX_DIMS      (MAX_DIMS),
      .DIM_SIZE_BITS (DIM_SIZE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_chan.valid),
      .csr_index   (csr_chan.index),
      .csr_data    (csr_chan.data),
      .range_start (req_chan.range_start),
      .range_step  (req_chan.range_step),
      .range_end   (req_chan.range_end),
      .cmd         (cmd),
      .stat        (stat),
      .status      (rsp_chan.status),
      .slice_width (rsp_chan.slice_width),
      .slice_count (rsp_chan.slice_count),
      .src_offset  (rsp_chan.src_offset),
      .dst_offset  (rsp_chan.dst_offset),
      .chunk_len   (rsp_chan.chunk_len),
      .last_chunk  (rsp_chan.last_chunk)
   );

endmodule

### design/ndslice_ctrl.sv
// ----------------------------------------------------------------------------
// ndslice_ctrl
// Sequencer: accepts one item, steps the datapath, presents the result.
// ----------------------------------------------------------------------------
module ndslice_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ndslice_pkg::stat_type stat,
   output ndslice_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIV  = 4'd1;
   localparam logic [3:0] S_CHK  = 4'd2;
   localparam logic [3:0] S_PROD = 4'd3;
   localparam logic [3:0] S_FIN1 = 4'd4;
   localparam logic [3:0] S_FIN2 = 4'd5;
   localparam logic [3:0] S_FIN3 = 4'd6;
   localparam logic [3:0] S_FIN4 = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == ndslice_pkg::OP_NEXT) begin
                  cmd.take_next = 1'b1;
                  state_in      = S_OUT;
               end else begin
                  cmd.take_start = 1'b1;
                  state_in       = stat.pre_fail ? S_OUT : S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_CHK;
         end
         S_CHK: begin
            cmd.check = 1'b1;
            state_in  = stat.oob ? S_OUT : S_PROD;
         end
         S_PROD: begin
            cmd.prod_step = 1'b1;
            if (stat.prod_last) state_in = S_FIN1;
         end
         S_FIN1: begin
            cmd.fin1 = 1'b1;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = S_FIN3;
         end
         S_FIN3: begin
            cmd.fin3 = 1'b1;
            state_in = S_FIN4;
         end
         S_FIN4: begin
            cmd.fin4 = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/ndslice_dp.sv
// ----------------------------------------------------------------------------
// ndslice_dp
// Datapath: registers, range check, restoring divider, dimension products and
// the chunk walker.
// ----------------------------------------------------------------------------
module ndslice_dp #(
   parameter int MAX_DIMS      = 4,
   parameter int DIM_SIZE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data,
   input  logic [31:0]           range_start,
   input  logic [31:0]           range_step,
   input  logic [31:0]           range_end,
   input  ndslice_pkg::cmd_type  cmd,
   output ndslice_pkg::stat_type stat,
   output logic [2:0]            status,
   output logic [15:0]           slice_width,
   output logic [31:0]           slice_count,
   output logic [31:0]           src_offset,
   output logic [31:0]           dst_offset,
   output logic [31:0]           chunk_len,
   output logic                  last_chunk
);

   localparam int MAX_EFF  = (MAX_DIMS < ndslice_pkg::NUM_SIZE_REGS) ?
                             MAX_DIMS : ndslice_pkg::NUM_SIZE_REGS;
   localparam int LEN_BITS = (DIM_SIZE_BITS < 16) ? DIM_SIZE_BITS : 16;
   localparam logic [15:0] LEN_MASK = 16'((33'd1 << LEN_BITS) - 33'd1);

   // configuration
   logic [2:0]  dim_count_ff;
   logic [15:0] size_ff [ndslice_pkg::NUM_SIZE_REGS];
   logic [1:0]  slice_dim_ff;

   // operands
   logic [31:0] s_ff, st_ff, e_ff;
   // divider
   logic [31:0] quo_ff, rem_ff, m_ff;
   logic [4:0]  dcnt_ff;
   // plan
   logic [15:0] width_ff;
   logic        whole_ff, contig_ff;
   logic [63:0] total_ff, cnt_ff, run_ff, row_ff;
   logic [1:0]  idx_ff, phase_ff;
   logic [31:0] start_run_ff, step_run_ff, clen_ff;
   // walker
   logic        active_ff;
   logic [63:0] outer_ff;
   logic [31:0] dst_ff, idx_run_ff;
   logic [15:0] rem_cnt_ff;
   // result register
   logic [2:0]  o_status_ff;
   logic [15:0] o_width_ff;
   logic [31:0] o_count_ff, o_src_ff, o_dst_ff, o_len_ff;
   logic        o_last_ff;

   logic [15:0] lens [ndslice_pkg::NUM_SIZE_REGS];
   logic [2:0]  dims_eff;
   logic [15:0] upper;
   logic        pos;
   logic [2:0]  pre_code;

   always_comb begin
      for (int i = 0; i < ndslice_pkg::NUM_SIZE_REGS; i++) lens[i] = size_ff[i] & LEN_MASK;
      if (dim_count_ff == 3'd0)               dims_eff = 3'd1;
      else if (int'(dim_count_ff) > MAX_EFF) dims_eff = 3'(MAX_EFF);
      else                                    dims_eff = dim_count_ff;
      upper = lens[slice_dim_ff];
   end

   // early checks on the incoming range
   always_comb begin
      pos = !range_step[31];
      if ({1'b0, slice_dim_ff} >= dims_eff)                      pre_code = ndslice_pkg::STAT_OOB;
      else if (range_step == 32'd0)                              pre_code = ndslice_pkg::STAT_ZSTEP;
      else if (pos && ($signed(range_end) < $signed(range_start))) pre_code = ndslice_pkg::STAT_EMPTY;
      else if (!pos && ($signed(range_start) < $signed(range_end)))
         pre_code = ndslice_pkg::STAT_EMPTY;
      else pre_code = ndslice_pkg::STAT_OK;
   end
   assign stat.pre_fail = (pre_code != ndslice_pkg::STAT_OK);

   // divider step
   logic [32:0] div_sh, div_diff;
   logic        div_ge;
   always_comb begin
      div_sh   = {rem_ff, quo_ff[31]};
      div_diff = div_sh - {1'b0, m_ff};
      div_ge   = (div_sh >= {1'b0, m_ff});
   end
   assign stat.div_last = (dcnt_ff == 5'd31);

   // bounds and normalisation from quotient and remainder
   logic        st_pos;
   logic [33:0] s34, st34, e34, last34, upper34, nend34;
   logic [32:0] width33;
   logic        w_is1, nstep_is1, whole_c;
   logic        oob_c;
   always_comb begin
      st_pos  = !st_ff[31];
      s34     = {{2{s_ff[31]}}, s_ff};
      st34    = {{2{st_ff[31]}}, st_ff};
      e34     = {{2{e_ff[31]}}, e_ff};
      upper34 = {18'd0, upper};
      last34  = st_pos ? (e34 - {2'b00, rem_ff}) : (e34 + {2'b00, rem_ff});
      width33 = {1'b0, quo_ff} + 33'd1;
      w_is1   = (quo_ff == 32'd0);
      nend34  = w_is1 ? (s34 + 34'd1) : (last34 + st34);
      nstep_is1 = w_is1 || (st_ff == 32'd1);
      whole_c = nstep_is1 && (s_ff == 32'd0) && (nend34 == upper34);
      if (st_pos) oob_c = ($signed(last34) >= $signed(upper34)) || s_ff[31];
      else        oob_c = last34[33] || ($signed(s34) >= $signed(upper34));
   end
   assign stat.oob = oob_c;

   // product loop: one shared 64x16 multiplier
   logic        prod_at_d, prod_past_d;
   logic [63:0] mula_x, mula_p;
   logic [15:0] mula_f, len_i;
   always_comb begin
      len_i       = lens[idx_ff];
      prod_at_d   = (idx_ff == slice_dim_ff);
      prod_past_d = (idx_ff > slice_dim_ff);
      mula_x = run_ff;
      mula_f = upper;
      if (cmd.prod_step) begin
         case (phase_ff)
            2'd0: begin
               mula_x = total_ff;
               mula_f = len_i;
            end
            2'd1: begin
               mula_x = cnt_ff;
               mula_f = prod_at_d ? width_ff : len_i;
            end
            default: begin
               mula_x = run_ff;
               mula_f = prod_past_d ? len_i : 16'd1;
            end
         endcase
      end
      mula_p = mula_x * mula_f;
   end
   assign stat.prod_last = ({1'b0, idx_ff} == dims_eff - 3'd1) && (phase_ff == 2'd2);

   // 32x32 low-half multiplier for the chunk increments
   logic [31:0] mulb_y, mulb_p;
   always_comb begin
      if (cmd.fin2)      mulb_y = whole_ff ? 32'd0 : s_ff;
      else if (cmd.fin3) mulb_y = st_ff;
      else               mulb_y = whole_ff ? 32'd1 : {16'd0, width_ff};
      mulb_p = run_ff[31:0] * mulb_y;
   end

   // chunk walker
   logic        wrap;
   logic [63:0] outer_in;
   logic [31:0] len_c;
   always_comb begin
      wrap     = contig_ff || (rem_cnt_ff == 16'd1);
      outer_in = wrap ? (outer_ff + row_ff) : outer_ff;
      len_c    = contig_ff ? clen_ff : run_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= 3'd1;
         size_ff[0]   <= 16'd0;
         size_ff[1]   <= 16'd1;
         size_ff[2]   <= 16'd1;
         size_ff[3]   <= 16'd1;
         slice_dim_ff <= 2'd0;
         active_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ndslice_pkg::CSR_DIM_COUNT: dim_count_ff <= csr_data[2:0];
               ndslice_pkg::CSR_SIZE0:     size_ff[0]   <= csr_data;
               ndslice_pkg::CSR_SIZE1:     size_ff[1]   <= csr_data;
               ndslice_pkg::CSR_SIZE2:     size_ff[2]   <= csr_data;
               ndslice_pkg::CSR_SIZE3:     size_ff[3]   <= csr_data;
               ndslice_pkg::CSR_SLICE_DIM: slice_dim_ff <= csr_data[1:0];
               default: ;
            endcase
         end
         if (cmd.take_start) active_ff <= 1'b0;
         if (cmd.fin4) begin
            active_ff <= whole_ff ? (total_ff != 64'd0)
                                  : ((cnt_ff != 64'd0) && (row_ff != 64'd0));
         end
         if (cmd.take_next && active_ff) active_ff <= (outer_in < total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_start) begin
         s_ff    <= range_start;
         st_ff   <= range_step;
         e_ff    <= range_end;
         quo_ff  <= pos ? (range_end - range_start) : (range_start - range_end);
         m_ff    <= pos ? range_step : (~range_step + 32'd1);
         rem_ff  <= 32'd0;
         dcnt_ff <= 5'd0;
         if (stat.pre_fail) begin
            o_status_ff <= pre_code;
            o_width_ff  <= 16'd0;
            o_count_ff  <= 32'd0;
            o_src_ff    <= 32'd0;
            o_dst_ff    <= 32'd0;
            o_len_ff    <= 32'd0;
            o_last_ff   <= 1'b0;
         end
      end
      if (cmd.div_step) begin
         rem_ff  <= div_ge ? div_diff[31:0] : div_sh[31:0];
         quo_ff  <= {quo_ff[30:0], div_ge};
         dcnt_ff <= dcnt_ff + 5'd1;
      end
      if (cmd.check) begin
         width_ff  <= width33[15:0];
         whole_ff  <= whole_c;
         contig_ff <= nstep_is1;
         total_ff  <= 64'd1;
         cnt_ff    <= 64'd1;
         run_ff    <= 64'd1;
         idx_ff    <= 2'd0;
         phase_ff  <= 2'd0;
         if (oob_c) begin
            o_status_ff <= ndslice_pkg::STAT_OOB;
            o_width_ff  <= 16'd0;
            o_count_ff  <= 32'd0;
            o_src_ff    <= 32'd0;
            o_dst_ff    <= 32'd0;
            o_len_ff    <= 32'd0;
            o_last_ff   <= 1'b0;
         end
      end
      if (cmd.prod_step) begin
         case (phase_ff)
            2'd0:    total_ff <= mula_p;
            2'd1:    cnt_ff   <= mula_p;
            default: run_ff   <= mula_p;
         endcase
         if (phase_ff == 2'd2) begin
            phase_ff <= 2'd0;
            idx_ff   <= idx_ff + 2'd1;
         end else begin
            phase_ff <= phase_ff + 2'd1;
         end
      end
      if (cmd.fin1) begin
         if (whole_ff) begin
            run_ff <= total_ff;
            row_ff <= total_ff;
         end else begin
            row_ff <= mula_p;
         end
      end
      if (cmd.fin2) start_run_ff <= mulb_p;
      if (cmd.fin3) step_run_ff  <= mulb_p;
      if (cmd.fin4) begin
         clen_ff     <= mulb_p;
         outer_ff    <= 64'd0;
         dst_ff      <= 32'd0;
         idx_run_ff  <= start_run_ff;
         rem_cnt_ff  <= width_ff;
         o_status_ff <= whole_ff ? ndslice_pkg::STAT_WHOLE : ndslice_pkg::STAT_OK;
         o_width_ff  <= width_ff;
         o_count_ff  <= whole_ff ? total_ff[31:0] : cnt_ff[31:0];
         o_src_ff    <= 32'd0;
         o_dst_ff    <= 32'd0;
         o_len_ff    <= 32'd0;
         o_last_ff   <= 1'b0;
      end
      if (cmd.take_next) begin
         o_width_ff <= 16'd0;
         o_count_ff <= 32'd0;
         if (!active_ff) begin
            o_status_ff <= ndslice_pkg::STAT_NONE;
            o_src_ff    <= 32'd0;
            o_dst_ff    <= 32'd0;
            o_len_ff    <= 32'd0;
            o_last_ff   <= 1'b0;
         end else begin
            o_status_ff <= ndslice_pkg::STAT_OK;
            o_src_ff    <= outer_ff[31:0] + (contig_ff ? start_run_ff : idx_run_ff);
            o_dst_ff    <= dst_ff;
            o_len_ff    <= len_c;
            o_last_ff   <= !(outer_in < total_ff);
            dst_ff      <= dst_ff + len_c;
            outer_ff    <= outer_in;
            if (!contig_ff) begin
               if (wrap) begin
                  idx_run_ff <= start_run_ff;
                  rem_cnt_ff <= width_ff;
               end else begin
                  idx_run_ff <= idx_run_ff + step_run_ff;
                  rem_cnt_ff <= rem_cnt_ff - 16'd1;
               end
            end
         end
      end
   end

   assign status      = o_status_ff;
   assign slice_width = o_width_ff;
   assign slice_count = o_count_ff;
   assign src_offset  = o_src_ff;
   assign dst_offset  = o_dst_ff;
   assign chunk_len   = o_len_ff;
   assign last_chunk  = o_last_ff;

endmodule

### design/ndslice_checker.sv
// ----------------------------------------------------------------------------
// ndslice_checker
// Port-level checks on the slice generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "nd_array_slice_chunk_generator_defines.svh"

module ndslice_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  status,
   input logic [31:0] chunk_len,
   input logic        last_chunk
);

   `NDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // one item at a time: no back-to-back transfers in
   `NDS_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)
   `NDS_ASSERT_IMPL(a_none_empty, clock, reset, rsp_valid && status == ndslice_pkg::STAT_NONE, chunk_len == 32'd0 && !last_chunk)
   `NDS_ASSERT_IMPL(a_last_ok, clock, reset, rsp_valid && last_chunk, status == ndslice_pkg::STAT_OK)

endmodule

bind nd_array_slice_chunk_generator ndslice_checker u_ndslice_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .status     (rsp_chan.status),
   .chunk_len  (rsp_chan.chunk_len),
   .last_chunk (rsp_chan.last_chunk)
);

### sim/nd_array_slice_chunk_generator_checker.sv
// ----------------------------------------------------------------------------
// nd_array_slice_chunk_generator_checker
// Watches the request, response and register channels of the slice chunk
// generator, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module nd_array_slice_chunk_generator_checker (
   input  logic          clock,
   input  logic          reset,
   ndslice_req_if        req_mon,
   ndslice_rsp_if        rsp_mon,
   ndslice_csr_if        csr_mon,
   output int            fail_count,
   output int            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] slice_width;
      logic [31:0] slice_count;
      logic [31:0] src_offset;
      logic [31:0] dst_offset;
      logic [31:0] chunk_len;
      logic        last_chunk;
   } slice_result_type;

   slice_result_type expected_results[$];

   // register copies
   logic [2:0]  dim_count;
   logic [15:0] dim_size[ndslice_pkg::NUM_SIZE_REGS];
   logic [1:0]  slice_dim;

   // walker state
   bit                  walking, contiguous;
   longint              first_idx, idx_step, end_excl, cur_idx;
   longint unsigned     run_len, row_len, total_elems, outer_pos, dst_pos;

   function automatic void clear_state();
      dim_count   = 3'd1;
      dim_size[0] = 16'd0;
      dim_size[1] = 16'd1;
      dim_size[2] = 16'd1;
      dim_size[3] = 16'd1;
      slice_dim   = 2'd0;
      walking     = 0;
      contiguous  = 0;
      first_idx   = 0;
      idx_step    = 1;
      end_excl    = 0;
      cur_idx     = 0;
      run_len     = 1;
      row_len     = 0;
      total_elems = 0;
      outer_pos   = 0;
      dst_pos     = 0;
      expected_results.delete();
   endfunction

   function automatic void push_result(logic [2:0] st, longint unsigned w, cnt, src, dst,
                                       len, bit last);
      slice_result_type r;
      r.status      = st;
      r.slice_width = w[15:0];
      r.slice_count = cnt[31:0];
      r.src_offset  = src[31:0];
      r.dst_offset  = dst[31:0];
      r.chunk_len   = len[31:0];
      r.last_chunk  = last;
      expected_results = {expected_results, r};
   endfunction

   function automatic void plan_slice(logic [31:0] s32, st32, e32);
      int              dims, d;
      longint          s, st, e, span, width, last_idx, upper;
      longint unsigned total, run, cnt, len;
      dims    = int'(dim_count);
      d       = int'(slice_dim);
      s       = $signed(s32);
      st      = $signed(st32);
      e       = $signed(e32);
      total   = 1;
      run     = 1;
      cnt     = 1;
      walking = 0;
      if (dims == 0) dims = 1;
      if (dims > ndslice_pkg::NUM_SIZE_REGS) dims = ndslice_pkg::NUM_SIZE_REGS;
      if (d >= dims) begin
         push_result(ndslice_pkg::STAT_OOB, 0, 0, 0, 0, 0, 0);
         return;
      end
      if (st == 0) begin
         push_result(ndslice_pkg::STAT_ZSTEP, 0, 0, 0, 0, 0, 0);
         return;
      end
      if ((st > 0 && e < s) || (st < 0 && s < e)) begin
         push_result(ndslice_pkg::STAT_EMPTY, 0, 0, 0, 0, 0, 0);
         return;
      end
      upper = dim_size[d];
      span  = (st > 0) ? e - s + 1 : e - s - 1;
      width = span / st + ((span % st) != 0 ? 1 : 0);
      last_idx = s + (width - 1) * st;
      if ((st > 0 && (last_idx >= upper || s < 0)) ||
          (st < 0 && (last_idx < 0 || s >= upper))) begin
         push_result(ndslice_pkg::STAT_OOB, 0, 0, 0, 0, 0, 0);
         return;
      end
      first_idx = s;
      idx_step  = st;
      end_excl  = last_idx + st;
      if (width == 1) begin
         idx_step = 1;
         end_excl = s + 1;
      end
      for (int i = 0; i < dims; i++) begin
         len   = dim_size[i];
         total = total * len;
         cnt   = cnt * ((i == d) ? longint'(width) : len);
         if (i > d) run = run * len;
      end
      total_elems = total;
      outer_pos   = 0;
      dst_pos     = 0;
      cur_idx     = first_idx;
      if (idx_step == 1 && first_idx == 0 && end_excl == upper) begin
         // whole dimension: a single chunk over the full array
         contiguous = 1;
         run_len    = total;
         row_len    = total;
         first_idx  = 0;
         end_excl   = 1;
         cur_idx    = 0;
         walking    = total != 0;
         push_result(ndslice_pkg::STAT_WHOLE, width, total, 0, 0, 0, 0);
         return;
      end
      run_len    = run;
      row_len    = run * longint'(upper);
      contiguous = idx_step == 1;
      walking    = cnt != 0 && row_len != 0;
      push_result(ndslice_pkg::STAT_OK, width, cnt, 0, 0, 0, 0);
   endfunction

   function automatic void next_chunk();
      longint unsigned src, len, dst;
      dst = dst_pos;
      if (!walking) begin
         push_result(ndslice_pkg::STAT_NONE, 0, 0, 0, 0, 0, 0);
         return;
      end
      if (contiguous) begin
         src       = outer_pos + run_len * longint'(first_idx);
         len       = run_len * longint'(end_excl - first_idx);
         outer_pos = outer_pos + row_len;
      end else begin
         src     = outer_pos + longint'(cur_idx) * run_len;
         len     = run_len;
         cur_idx = cur_idx + idx_step;
         if (cur_idx == end_excl) begin
            cur_idx   = first_idx;
            outer_pos = outer_pos + row_len;
         end
      end
      dst_pos = dst_pos + len;
      if (outer_pos >= total_elems) walking = 0;
      push_result(ndslice_pkg::STAT_OK, 0, 0, src, dst, len, !walking);
   endfunction

   function automatic void check_field(string name, longint unsigned exp_v, logic [31:0] act_v,
                                       int w);
      logic [31:0] mask;
      mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
      if ((act_v & mask) !== (exp_v[31:0] & mask) || $isunknown(act_v & mask)) begin
         $error("%s: expected %0d, got %0d", name, exp_v[31:0] & mask, act_v & mask);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      slice_result_type r;
      if (reset) begin
         clear_state();
         fail_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               ndslice_pkg::CSR_DIM_COUNT: dim_count   = csr_mon.data[2:0];
               ndslice_pkg::CSR_SIZE0:     dim_size[0] = csr_mon.data;
               ndslice_pkg::CSR_SIZE1:     dim_size[1] = csr_mon.data;
               ndslice_pkg::CSR_SIZE2:     dim_size[2] = csr_mon.data;
               ndslice_pkg::CSR_SIZE3:     dim_size[3] = csr_mon.data;
               ndslice_pkg::CSR_SLICE_DIM: slice_dim   = csr_mon.data[1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("response transfer with nothing expected");
               fail_count++;
            end else begin
               r = expected_results.pop_front();
               check_field("status", r.status, rsp_mon.status, 3);
               check_field("slice_width", r.slice_width, rsp_mon.slice_width, 16);
               check_field("slice_count", r.slice_count, rsp_mon.slice_count, 32);
               check_field("src_offset", r.src_offset, rsp_mon.src_offset, 32);
               check_field("dst_offset", r.dst_offset, rsp_mon.dst_offset, 32);
               check_field("chunk_len", r.chunk_len, rsp_mon.chunk_len, 32);
               check_field("last_chunk", r.last_chunk, rsp_mon.last_chunk, 1);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.operation == ndslice_pkg::OP_START)
               plan_slice(req_mon.range_start, req_mon.range_step, req_mon.range_end);
            else
               next_chunk();
         end
      end
      pending = expected_results.size();
   end

endmodule

### sim/nd_array_slice_chunk_generator_test.sv
// ----------------------------------------------------------------------------
// nd_array_slice_chunk_generator_test
// Drives slice starts and chunk requests over a range of array shapes, with
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module nd_array_slice_chunk_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 5000;
   localparam int TARGET_ITEMS = 1750;
   localparam int NUM_PHASES   = 8;

   logic clock;
   logic reset;
   int   fail_count, pending;
   int   items_sent;
   int   send_idle_pct, recv_stall_pct;
   int   hold_request, hold_seen, hold_left, quiet_cycles;

   logic [2:0]  cur_dims;
   logic [15:0] cur_size[ndslice_pkg::NUM_SIZE_REGS];
   logic [1:0]  cur_slice_dim;

   ndslice_req_if req_if ();
   ndslice_rsp_if rsp_if ();
   ndslice_csr_if csr_if ();

   nd_array_slice_chunk_generator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   nd_array_slice_chunk_generator_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_mon    (csr_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_seen    <= 0;
         hold_left    <= 0;
      end else if (hold_request != hold_seen) begin
         hold_seen    <= hold_request;
         hold_left    <= 300;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("nd_array_slice_chunk_generator regression: fail");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic send_item(logic op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.operation   <= op;
      req_if.range_start <= a;
      req_if.range_step  <= b;
      req_if.range_end   <= c;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   task automatic send_next();
      send_item(ndslice_pkg::OP_NEXT, $urandom, $urandom, $urandom);
   endtask

   // the edge first lets the checker count the last transfer in
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(logic [2:0] dims, logic [15:0] s0, s1, s2, s3, logic [1:0] sd);
      cur_dims      = dims;
      cur_size      = '{s0, s1, s2, s3};
      cur_slice_dim = sd;
      csr_write(ndslice_pkg::CSR_DIM_COUNT, {13'd0, dims});
      csr_write(ndslice_pkg::CSR_SIZE0, s0);
      csr_write(ndslice_pkg::CSR_SIZE1, s1);
      csr_write(ndslice_pkg::CSR_SIZE2, s2);
      csr_write(ndslice_pkg::CSR_SIZE3, s3);
      csr_write(ndslice_pkg::CSR_SLICE_DIM, {14'd0, sd});
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // a start item, mostly a well-formed range within the sliced dimension
   task automatic send_start();
      int unsigned upper, x, y, mag, kind;
      logic [31:0] s, st, e;
      upper = cur_size[cur_slice_dim];
      kind  = $urandom_range(99);
      if (upper == 0 && kind < 70) kind = 95;
      if (kind < 10) begin
         s = 0; st = 1; e = upper - 1;
      end else if (kind < 70) begin
         x = $urandom_range(upper - 1, 0);
         y = $urandom_range(upper - 1, 0);
         case ($urandom_range(3))
            0, 1: mag = 1;
            2:    mag = $urandom_range(5, 2);
            default: mag = $urandom_range(upper, 1);
         endcase
         if ($urandom_range(1)) begin
            s = (x < y) ? x : y; e = (x < y) ? y : x; st = mag;
         end else begin
            s = (x < y) ? y : x; e = (x < y) ? x : y; st = -mag;
         end
      end else if (kind < 77) begin
         s = $urandom; st = 0; e = $urandom;
      end else if (kind < 84) begin
         s = $urandom_range(upper + 3, 1); e = s - $urandom_range(5, 1); st = 1;
      end else if (kind < 92) begin
         s = upper + $urandom_range(4); st = $urandom_range(3, 1); e = s + 10;
      end else begin
         s = $urandom; st = $urandom; e = $urandom;
      end
      send_item(ndslice_pkg::OP_START, s, st, e);
   endtask

   initial begin
      int phase, chunks;
      reset          = 1'b1;
      hold_request   = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      items_sent     = 0;
      req_if.valid       <= 1'b0;
      req_if.operation   <= ndslice_pkg::OP_START;
      req_if.range_start <= '0;
      req_if.range_step  <= '0;
      req_if.range_end   <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= ndslice_pkg::CSR_DIM_COUNT;
      csr_if.data        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one dimension of ten
      configure(3'd1, 16'd10, 16'd1, 16'd1, 16'd1, 2'd0);
      send_next();                                          // nothing pending
      send_item(ndslice_pkg::OP_START, 0, 1, 9);            // whole dimension
      send_next();
      send_next();
      send_item(ndslice_pkg::OP_START, 3, 5, 3);            // single index
      send_next();
      send_item(ndslice_pkg::OP_START, 4, 0, 6);            // zero step
      send_item(ndslice_pkg::OP_START, 5, 1, 2);            // empty forward
      send_item(ndslice_pkg::OP_START, 2, -1, 5);           // empty reversed
      send_item(ndslice_pkg::OP_START, 0, 1, 10);           // past the end
      send_item(ndslice_pkg::OP_START, -1, 1, 3);           // negative start
      send_item(ndslice_pkg::OP_START, 9, -3, 0);           // reversed, strided
      repeat (5) send_next();
      send_item(ndslice_pkg::OP_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(ndslice_pkg::OP_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_item(ndslice_pkg::OP_START, 1, 2, 8);
      send_next();
      send_item(ndslice_pkg::OP_START, 2, 1, 7);            // abandons the previous slice
      repeat (3) send_next();
      drain();

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: configure(3'd3, 16'd4, 16'd5, 16'd6, 16'd1, 2'd1);
            1: configure(3'd4, 16'd3, 16'd2, 16'd4, 16'd5, 2'd3);
            2: configure(3'd2, 16'd65535, 16'd0, 16'd1, 16'd1, 2'd0);
            3: configure(3'd7, 16'd2, 16'd3, 16'd65535, 16'd1, 2'd2);
            4: configure(3'd0, 16'd0, 16'd7, 16'd7, 16'd7, 2'd0);
            5: configure(3'd4, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 2'd1);
            6: configure(3'd2, 16'd7, 16'd9, 16'd3, 16'd3, 2'd2);
            default: configure(3'd4, 16'd5, 16'd1, 16'd3, 16'd2, 2'd0);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         while (items_sent < TARGET_ITEMS * (phase + 1) / NUM_PHASES + 25) begin
            if ($urandom_range(9) == 0) begin
               send_next();
            end else begin
               send_start();
               chunks = $urandom_range(25);
               repeat (chunks) send_next();
            end
            if (phase == 1 && hold_request == 0) begin
               hold_request = 1;       // receiver holds off; keep offering
               repeat (20) send_next();
            end
            if (phase == 3 && $urandom_range(49) == 0) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
               wait (pending == 0);
            end
         end
         send_idle_pct  = 0;
         recv_stall_pct = 0;
         drain();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("nd_array_slice_chunk_generator regression: pass");
      else
         $display("nd_array_slice_chunk_generator regression: fail");
      $finish;
   end

endmodule
